// ===== rtl/mpt_pkg.sv =====
// shared types and codes of the memory partition table
`default_nettype none
package mpt_pkg;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] base_address;
    logic [31:0] region_length;
    logic [31:0] access_bits;
  } mpt_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [4:0] used_count;
  } mpt_rsp_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
    logic [31:0] access;
  } mpt_entry_t;

endpackage
`default_nettype wire

// ===== rtl/memory_partition_table_top.sv =====
// memory partition table top level: slot limit register, sequencer and slot storage
`default_nettype none
// Partition table of SLOTS entries held in a synchronous RAM. A request is taken
// when start_i is high and busy_o is low; its result appears on rsp_o for one
// cycle with done_o high and must be taken then. Add and remove walk the RAM one
// slot per cycle through its single read port, scanning up to all SLOTS slots,
// and finish early when a remove matches or an add hits an overlap. Clear, an
// unknown operation and an add rejected for zero length or wraparound give their
// result in the next cycle. busy_o drops in the cycle that shows the result, so
// a new request can be taken there. Slot limit writes are registered; the user
// must make them only while idle, which the block itself does not enforce.
module memory_partition_table_top
  import mpt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire mpt_req_t   req_i,
  output logic            done_o,
  output mpt_rsp_t        rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [4:0]       limit_q;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  mpt_entry_t       rd_data, wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  mpt_scan_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_i     (req_i),
    .limit_i   (limit_q),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  mpt_slot_mem #(
    .DEPTH  (SLOTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule
`default_nettype wire

// ===== rtl/mpt_slot_mem.sv =====
// slot table storage: one write port, one registered read port
`default_nettype none
module mpt_slot_mem
  import mpt_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output mpt_entry_t             rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire mpt_entry_t        wr_data_i
);

  mpt_entry_t mem_q [DEPTH];
  mpt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/mpt_scan_ctrl.sv =====
// request sequencer: slot scan, overlap and match checks, valid bits and count
`default_nettype none
module mpt_scan_ctrl
  import mpt_pkg::*;
#(
  parameter int SLOTS  = 16,
  parameter int IDX_W  = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire mpt_req_t         req_i,
  input  wire logic [4:0]       limit_i,
  output logic                  done_o,
  output mpt_rsp_t              rsp_o,
  output logic                  rd_en_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  input  wire mpt_entry_t       rd_data_i,
  output logic                  wr_en_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output mpt_entry_t            wr_data_o
);

  localparam int LIM_W = $clog2(SLOTS + 1);
  localparam int CW    = (LIM_W > 5) ? LIM_W : 5;
  localparam int XW    = (IDX_W > 4) ? IDX_W : 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e               state_q;
  mpt_req_t             req_q;
  logic [IDX_W-1:0]     addr_q;
  logic                 last_iss_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [SLOTS-1:0]     valid_q;
  logic [LIM_W-1:0]     occ_q;
  logic                 done_q;
  mpt_rsp_t             rsp_q;

  logic [CW-1:0]        lim_ext, eff_lim;
  logic                 in_lim, used;
  logic [31:0]          req_end, ent_end;
  logic                 overlap, match, free_here, last_cmp, finish;
  logic                 free_avail;
  logic [IDX_W-1:0]     free_sel;
  logic [32:0]          add_sum;
  logic                 add_bad;
  logic                 accept;

  function automatic logic [3:0] idx4(input logic [IDX_W-1:0] idx);
    logic [XW-1:0] ext;
    ext = XW'(idx);
    return ext[3:0];
  endfunction

  function automatic logic [4:0] cnt5(input logic [LIM_W-1:0] cnt);
    logic [CW-1:0] ext;
    ext = CW'(cnt);
    return ext[4:0];
  endfunction

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // limits above the built slot count saturate
  assign lim_ext = CW'(limit_i);
  assign eff_lim = (lim_ext > CW'(SLOTS)) ? CW'(SLOTS) : lim_ext;
  assign in_lim  = (CW'(cmp_idx_q) < eff_lim);
  assign used    = valid_q[cmp_idx_q];

  assign add_sum = {1'b0, req_i.base_address} + {1'b0, req_i.region_length};
  assign add_bad = (req_i.region_length == 32'd0) || add_sum[32];

  assign req_end = req_q.base_address + req_q.region_length;
  assign ent_end = rd_data_i.base + rd_data_i.length;

  // overlap scan covers every used slot, the limit only bounds placing and removal
  assign overlap   = cmp_vld_q && used && (req_end > rd_data_i.base) &&
                     (ent_end > req_q.base_address);
  assign match     = cmp_vld_q && used && in_lim &&
                     (rd_data_i.base == req_q.base_address) &&
                     (rd_data_i.length == req_q.region_length);
  assign free_here = cmp_vld_q && !used && in_lim;
  assign last_cmp  = cmp_vld_q && (cmp_idx_q == LAST_IDX);

  always_comb begin
    if (req_q.operation == OP_ADD) begin
      finish = overlap || last_cmp;
    end else begin
      finish = match || last_cmp;
    end
    finish = finish && (state_q == S_SCAN);
  end

  assign free_avail = free_found_q || free_here;
  assign free_sel   = free_found_q ? free_idx_q : cmp_idx_q;

  assign rd_en_o   = (state_q == S_SCAN) && !last_iss_q;
  assign rd_addr_o = addr_q;

  assign wr_en_o   = finish && (req_q.operation == OP_ADD) && !overlap && free_avail;
  assign wr_addr_o = free_sel;
  assign wr_data_o = '{base:   req_q.base_address,
                       length: req_q.region_length,
                       access: req_q.access_bits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      addr_q       <= '0;
      last_iss_q   <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      occ_q        <= '0;
      done_q       <= 1'b0;
      rsp_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q        <= req_i;
            addr_q       <= '0;
            last_iss_q   <= 1'b0;
            cmp_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            case (req_i.operation)
              OP_ADD: begin
                if (add_bad) begin
                  done_q <= 1'b1;
                  rsp_q  <= '{status: ST_INVALID, slot_index: 4'd0,
                              used_count: cnt5(occ_q)};
                end else begin
                  state_q <= S_SCAN;
                end
              end
              OP_REMOVE: begin
                state_q <= S_SCAN;
              end
              OP_CLEAR: begin
                valid_q <= '0;
                occ_q   <= '0;
                done_q  <= 1'b1;
                rsp_q   <= '{status: ST_OK, slot_index: 4'd0, used_count: 5'd0};
              end
              default: begin
                done_q <= 1'b1;
                rsp_q  <= '{status: ST_INVALID, slot_index: 4'd0,
                            used_count: cnt5(occ_q)};
              end
            endcase
          end
        end
        S_SCAN: begin
          // one read issued and one entry compared per cycle
          cmp_vld_q <= rd_en_o;
          cmp_idx_q <= addr_q;
          if (rd_en_o) begin
            if (addr_q == LAST_IDX) begin
              last_iss_q <= 1'b1;
            end else begin
              addr_q <= addr_q + 1'b1;
            end
          end
          if (free_here && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
          if (finish) begin
            state_q   <= S_IDLE;
            cmp_vld_q <= 1'b0;
            done_q    <= 1'b1;
            if (req_q.operation == OP_ADD) begin
              if (overlap) begin
                rsp_q <= '{status: ST_INVALID, slot_index: 4'd0,
                           used_count: cnt5(occ_q)};
              end else if (free_avail) begin
                valid_q[free_sel] <= 1'b1;
                occ_q             <= occ_q + 1'b1;
                rsp_q <= '{status: ST_OK, slot_index: idx4(free_sel),
                           used_count: cnt5(occ_q + 1'b1)};
              end else begin
                rsp_q <= '{status: ST_NOSPACE, slot_index: 4'd0,
                           used_count: cnt5(occ_q)};
              end
            end else begin
              if (match) begin
                valid_q[cmp_idx_q] <= 1'b0;
                occ_q              <= occ_q - 1'b1;
                rsp_q <= '{status: ST_OK, slot_index: idx4(cmp_idx_q),
                           used_count: cnt5(occ_q - 1'b1)};
              end else begin
                rsp_q <= '{status: ST_NOMATCH, slot_index: 4'd0,
                           used_count: cnt5(occ_q)};
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) == $countones(valid_q))
    else $error("used count differs from number of valid slots");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !valid_q[wr_addr_o])
    else $error("add writes a slot that is in use");

  a_fail_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> rsp_o.slot_index == 4'd0)
    else $error("failed request reports a slot index");

  a_no_result_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !done_o)
    else $error("result strobe while a scan is running");

  a_scan_after_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation == OP_REMOVE) |=> busy_o)
    else $error("remove request did not start a scan");

endmodule
`default_nettype wire

// ===== tb/memory_partition_table_checker.sv =====
// checker for the memory partition table: tracks requests, predicts and compares results
`default_nettype none
module memory_partition_table_checker
  import mpt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       busy_i,
  input  wire mpt_req_t   req_i,
  input  wire logic       done_i,
  input  wire mpt_rsp_t   rsp_i,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] tab_base   [SLOTS];
  logic [31:0] tab_length [SLOTS];
  logic [31:0] tab_access [SLOTS];
  int          used_slots = 0;
  logic [4:0]  slot_limit = LIMIT_RESET;
  mpt_rsp_t    awaited_rsp [$];

  // applies one request to the shadow table and returns its result
  function automatic mpt_rsp_t predict_outcome(input mpt_req_t r);
    mpt_rsp_t    res;
    logic [31:0] last;
    int          lim;
    int          slot;
    logic        clash;
    res   = '0;
    slot  = -1;
    lim   = (int'(slot_limit) > SLOTS) ? SLOTS : int'(slot_limit);
    res.status = ST_OK;
    case (r.operation)
      OP_ADD: begin
        last  = r.base_address + r.region_length;
        clash = (r.region_length == '0) || (last <= r.base_address);
        // overlap scan covers the whole table, not just slots below the limit
        for (int i = 0; i < SLOTS; i++) begin
          if (tab_length[i] != '0 && last > tab_base[i] &&
              tab_base[i] + tab_length[i] > r.base_address) clash = 1'b1;
        end
        if (clash) begin
          res.status = ST_INVALID;
        end else begin
          for (int i = 0; i < lim; i++) begin
            if (slot < 0 && tab_length[i] == '0) slot = i;
          end
          if (slot < 0) begin
            res.status = ST_NOSPACE;
          end else begin
            tab_base[slot]   = r.base_address;
            tab_length[slot] = r.region_length;
            tab_access[slot] = r.access_bits;
            used_slots++;
            res.slot_index = 4'(slot);
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < lim; i++) begin
          if (slot < 0 && tab_length[i] != '0 && tab_base[i] == r.base_address &&
              tab_length[i] == r.region_length) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_NOMATCH;
        end else begin
          tab_length[slot] = '0;
          if (used_slots > 0) used_slots--;
          res.slot_index = 4'(slot);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tab_length[i] = '0;
        used_slots = 0;
      end
      default: res.status = ST_INVALID;
    endcase
    res.used_count = 5'(used_slots);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mpt_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tab_base[i]   = '0;
        tab_length[i] = '0;
        tab_access[i] = '0;
      end
      used_slots   = 0;
      slot_limit   = LIMIT_RESET;
      fail_count_o = 0;
      awaited_rsp.delete();
    end else begin
      // the result leaving now belongs to an earlier request than one taken now
      if (done_i) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d slot %0d count %0d",
                   $time, rsp_i.status, rsp_i.slot_index, rsp_i.used_count);
          fail_count_o++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_i.status !== want.status || rsp_i.slot_index !== want.slot_index ||
              rsp_i.used_count !== want.used_count) begin
            $display("%0t: mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                     $time, want.status, want.slot_index, want.used_count,
                     rsp_i.status, rsp_i.slot_index, rsp_i.used_count);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) slot_limit = cfg_wdata_i;
      if (start_i && !busy_i) awaited_rsp.push_back(predict_outcome(req_i));
    end
    pending_o = awaited_rsp.size();
  end

endmodule
`default_nettype wire

// ===== tb/memory_partition_table_top_test.sv =====
// test top for the memory partition table: clock, reset, request stimulus and verdict
`default_nettype none
module memory_partition_table_top_test;
  import mpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS           = 16;
  localparam int ITEMS_PER_PHASE = 210;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  mpt_req_t   req_i = '0;
  logic       done_o;
  mpt_rsp_t   rsp_o;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  int         fail_count;
  int         pending;

  mpt_req_t   add_history [$];

  memory_partition_table_top #(.SLOTS(SLOTS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  memory_partition_table_checker #(.SLOTS(SLOTS)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .done_i      (done_o),
    .rsp_i       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send(input mpt_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic idle(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [4:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic mpt_req_t req_of(input logic [1:0] op, input logic [31:0] base,
                                      input logic [31:0] len, input logic [31:0] acc);
    mpt_req_t r;
    r.operation     = op;
    r.base_address  = base;
    r.region_length = len;
    r.access_bits   = acc;
    return r;
  endfunction

  function automatic mpt_req_t random_request();
    mpt_req_t r;
    int       pick;
    r.access_bits = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45 || pick >= 96) begin
      // partitions on a small page grid so that adds, overlaps and removes meet
      r.operation     = OP_ADD;
      r.base_address  = 32'($urandom_range(0, 47)) << 12;
      if ($urandom_range(0, 3) == 0) r.base_address += 32'($urandom_range(0, 4095));
      r.region_length = 32'($urandom_range(1, 3)) << 12;
      add_history.push_back(r);
    end else if (pick < 53) begin
      r.operation    = OP_ADD;
      r.base_address = $urandom();
      case ($urandom_range(0, 3))
        0:       r.region_length = '0;
        1:       r.region_length = $urandom();
        2:       r.region_length = ~r.base_address + 32'd1;  // ends exactly at 2^32
        default: r.region_length = 32'($urandom_range(1, 255));
      endcase
    end else if (pick < 80 && add_history.size() > 0) begin
      r = add_history[$urandom_range(0, add_history.size() - 1)];
      r.operation   = OP_REMOVE;
      r.access_bits = $urandom();
    end else if (pick < 88) begin
      r.operation     = OP_REMOVE;
      r.base_address  = $urandom();
      r.region_length = ($urandom_range(0, 2) == 0) ? '0 : $urandom();
    end else if (pick < 90) begin
      r.operation     = OP_CLEAR;
      r.base_address  = $urandom();
      r.region_length = $urandom();
    end else if (pick < 92) begin
      r.operation     = OP_RESERVED;
      r.base_address  = $urandom();
      r.region_length = $urandom();
    end else begin
      // top of the address space, ending one below the wrap point
      r.operation     = OP_ADD;
      r.region_length = 32'($urandom_range(1, 4096));
      r.base_address  = 32'hFFFF_FFFF - r.region_length;
      add_history.push_back(r);
    end
    if (add_history.size() > 40) void'(add_history.pop_front());
    return r;
  endfunction

  initial begin
    #10_000_000;
    $display("** memory_partition_table_top: FAILED **");
    $finish;
  end

  initial begin
    logic [4:0] phase_limit [8];
    int         sent;
    int         burst;
    int         gap;
    phase_limit = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd9, 5'd1, 5'd16, 5'd20};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, extremes, remove and clear at the reset limit
    send(req_of(OP_ADD,      32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(req_of(OP_ADD,      32'hFFFF_F000, 32'h0000_1000, 32'h0000_0000));
    send(req_of(OP_ADD,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(req_of(OP_ADD,      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
    send(req_of(OP_ADD,      32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000));
    send(req_of(OP_ADD,      32'h0000_0000, 32'h0000_0010, 32'hA5A5_A5A5));
    send(req_of(OP_ADD,      32'h0000_0001, 32'h7FFF_FFFF, 32'h5555_5555));
    send(req_of(OP_REMOVE,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(req_of(OP_REMOVE,   32'h0000_0000, 32'h0000_0001, 32'h0000_0000));
    send(req_of(OP_REMOVE,   32'h0000_0000, 32'h0000_0001, 32'h0000_0000));
    send(req_of(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(req_of(OP_ADD,      32'h0000_0000, 32'h0000_0001, 32'h1234_5678));
    send(req_of(OP_CLEAR,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(req_of(OP_REMOVE,   32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000));

    // small limit: table full
    set_limit(5'd2);
    send(req_of(OP_ADD,    32'h0000_0100, 32'h0000_0100, 32'h0000_0001));
    send(req_of(OP_ADD,    32'h0000_0300, 32'h0000_0100, 32'h0000_0002));
    send(req_of(OP_ADD,    32'h0000_0500, 32'h0000_0100, 32'h0000_0003));
    // lowered limit: overlap still seen above it, remove is not
    set_limit(5'd1);
    send(req_of(OP_ADD,    32'h0000_0380, 32'h0000_0010, 32'h0000_0004));
    send(req_of(OP_REMOVE, 32'h0000_0300, 32'h0000_0100, 32'h0000_0000));
    send(req_of(OP_REMOVE, 32'h0000_0100, 32'h0000_0100, 32'h0000_0000));
    set_limit(5'd0);
    send(req_of(OP_ADD,    32'h0000_0900, 32'h0000_0010, 32'h0000_0005));
    send(req_of(OP_REMOVE, 32'h0000_0300, 32'h0000_0100, 32'h0000_0000));

    foreach (phase_limit[p]) begin
      set_limit(phase_limit[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
          send(random_request());
          sent++;
        end
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) wait_drained();
        else if (gap > 0) idle(gap);
      end
    end

    wait_drained();
    repeat (SLOTS + 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** memory_partition_table_top: PASSED **");
    end else begin
      $display("** memory_partition_table_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
